### rtl/tcch_pkg.sv
// ----------------------------------------------------------------------------
// tcch_pkg: shared types and constants for the compass heading unit
// Field widths, CORDIC formats, the arctangent table, the controller state
// type and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tcch_pkg;

  // Field widths of the input and result words.
  localparam int RAW_W  = 11;
  localparam int TILT_W = 8;
  localparam int HEAD_W = 9;
  localparam int COMP_W = 11;

  // Iteration count shared by both CORDIC modes.
  localparam int ITER_STEPS = 16;
  localparam int STEP_W     = 4;

  // Magnitude width of a sum of up to 32 readings.
  localparam int DIV_W = 16;

  // CORDIC datapath: Q4.30 vectors, angles in 1/65536 degree.
  localparam int CORDIC_W  = 34;
  localparam int ANG_W     = 27;
  localparam int DEG_FRAC  = 16;
  localparam int VEC_SHIFT = 20;
  localparam int Q30_FRAC  = 30;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CORDIC_W-1:0] ONE_Q30         = 34'sd1073741824;

  localparam logic signed [ANG_W-1:0] ANG_90  = 27'sd5898240;
  localparam logic signed [ANG_W-1:0] ANG_180 = 27'sd11796480;
  localparam logic signed [ANG_W-1:0] ANG_270 = 27'sd17694720;
  localparam logic signed [ANG_W-1:0] ANG_360 = 27'sd23592960;

  // Whole-degree limits used when folding a tilt and clamping a heading.
  localparam logic [TILT_W:0]   DEG_QUARTER = 9'd90;
  localparam logic [TILT_W:0]   DEG_HALF    = 9'd180;
  localparam logic [HEAD_W-1:0] HEAD_MAX    = 9'd359;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ITER,
    S_COSF,
    S_MUL,
    S_SAT,
    S_VINIT,
    S_VEC,
    S_FOLD
  } tcch_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              accum;
    logic              load;
    logic              iter;
    logic              cosf;
    logic              mul;
    logic              sat;
    logic              vinit;
    logic              vstep;
    logic              fold;
    logic [STEP_W-1:0] step;
  } tcch_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic vec_zero;
  } tcch_status_t;

  // Arctangent of 2^-i in 1/65536 degree.
  function automatic logic signed [ANG_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
    logic signed [ANG_W-1:0] val;
    case (idx)
      4'd0:    val = 27'sd2949120;
      4'd1:    val = 27'sd1740967;
      4'd2:    val = 27'sd919879;
      4'd3:    val = 27'sd466945;
      4'd4:    val = 27'sd234379;
      4'd5:    val = 27'sd117304;
      4'd6:    val = 27'sd58666;
      4'd7:    val = 27'sd29335;
      4'd8:    val = 27'sd14668;
      4'd9:    val = 27'sd7334;
      4'd10:   val = 27'sd3667;
      4'd11:   val = 27'sd1833;
      4'd12:   val = 27'sd917;
      4'd13:   val = 27'sd458;
      4'd14:   val = 27'sd229;
      default: val = 27'sd115;
    endcase
    return val;
  endfunction

endpackage

### rtl/tcch_if.sv
// ----------------------------------------------------------------------------
// tcch_if: channel interfaces of the compass heading unit
// One interface for the input words and one for the result words, each
// with valid, ready and the payload fields.
// ----------------------------------------------------------------------------

// Input channel: raw compass readings and tilt averages.
interface tcch_in_if import tcch_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [RAW_W-1:0]  compass_x_raw;
  logic        [RAW_W-1:0]  compass_y_raw;
  logic signed [TILT_W-1:0] tilt_x_deg;
  logic signed [TILT_W-1:0] tilt_y_deg;

  modport source (
    output valid, compass_x_raw, compass_y_raw, tilt_x_deg, tilt_y_deg,
    input  ready
  );
  modport sink (
    input  valid, compass_x_raw, compass_y_raw, tilt_x_deg, tilt_y_deg,
    output ready
  );
endinterface

// Result channel: heading and compensated averages.
interface tcch_out_if import tcch_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [HEAD_W-1:0] heading_deg;
  logic signed [COMP_W-1:0] comp_x_avg;
  logic signed [COMP_W-1:0] comp_y_avg;

  modport source (
    output valid, heading_deg, comp_x_avg, comp_y_avg,
    input  ready
  );
  modport sink (
    input  valid, heading_deg, comp_x_avg, comp_y_avg,
    output ready
  );
endinterface

### rtl/tcch_ctrl.sv
// ----------------------------------------------------------------------------
// tcch_ctrl: sequencer of the compass heading unit
// Counts accumulated words, steps the datapath through divide, cosine,
// multiply and vectoring phases, and owns the result valid flag.
// ----------------------------------------------------------------------------
module tcch_ctrl import tcch_pkg::*; #(
  parameter int SAMPLES_PER_AVERAGE = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  tcch_status_t status,
  output tcch_cmd_t    cmd
);

  localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(SAMPLES_PER_AVERAGE);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ITER_STEPS - 1);

  tcch_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  // State, counters and result flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.step      = step_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (count_r == CNT_FULL) begin
            // This word closes the period and starts the computation.
            cmd.load  = 1'b1;
            count_nxt = '0;
            step_nxt  = '0;
            state_nxt = S_ITER;
          end else begin
            cmd.accum = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = S_COSF;
        end
      end
      S_COSF: begin
        cmd.cosf  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_VINIT;
      end
      S_VINIT: begin
        cmd.vinit = 1'b1;
        step_nxt  = '0;
        state_nxt = S_VEC;
      end
      S_VEC: begin
        // A zero residual ends the vectoring early.
        if (status.vec_zero) begin
          state_nxt = S_FOLD;
        end else begin
          cmd.vstep = 1'b1;
          step_nxt  = step_r + STEP_W'(1);
          if (step_r == LAST_STEP) begin
            state_nxt = S_FOLD;
          end
        end
      end
      S_FOLD: begin
        // Wait for the result register to be free.
        if (!out_valid_r || out_ready) begin
          cmd.fold      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/tcch_dpath.sv
// ----------------------------------------------------------------------------
// tcch_dpath: datapath of the compass heading unit
// Two lanes (X and Y) each hold a running sum, a reciprocal-multiply divider
// by the period length, a rotation CORDIC for the tilt cosine and a
// multiplier; a shared vectoring CORDIC turns the compensated pair into a
// heading.
// ----------------------------------------------------------------------------
module tcch_dpath import tcch_pkg::*; #(
  parameter int SAMPLES_PER_AVERAGE = 8,
  parameter int COS_FRAC_BITS       = 14
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tcch_cmd_t                cmd,
  input  logic        [RAW_W-1:0]  compass_x_raw,
  input  logic        [RAW_W-1:0]  compass_y_raw,
  input  logic signed [TILT_W-1:0] tilt_x_deg,
  input  logic signed [TILT_W-1:0] tilt_y_deg,
  output tcch_status_t             status,
  output logic        [HEAD_W-1:0] heading_deg,
  output logic signed [COMP_W-1:0] comp_x_avg,
  output logic signed [COMP_W-1:0] comp_y_avg
);

  localparam int SUM_W  = $clog2(SAMPLES_PER_AVERAGE) + RAW_W;
  localparam int COS_W  = COS_FRAC_BITS + 2;
  localparam int PROD_W = COMP_W + COS_W;
  localparam int LANES  = 2;

  // Division by the period length as a multiply by a rounded-up reciprocal;
  // exact for every magnitude below 2^DIV_W.
  localparam int RECIP_SH = DIV_W + $clog2(SAMPLES_PER_AVERAGE);
  localparam int RECIP_W  = DIV_W + 2;
  localparam int QPROD_W  = DIV_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(SAMPLES_PER_AVERAGE) - 64'd1) /
             64'(SAMPLES_PER_AVERAGE));

  localparam logic signed [CORDIC_W-1:0] ROUND_Q30 =
    CORDIC_W'(64'sd1 <<< (Q30_FRAC - 1 - COS_FRAC_BITS));
  localparam logic signed [COS_W-1:0] COS_ONE = COS_W'(64'sd1 <<< COS_FRAC_BITS);
  localparam logic signed [PROD_W-1:0] TRUNC_BIAS =
    PROD_W'((64'sd1 <<< COS_FRAC_BITS) - 64'sd1);
  localparam logic signed [PROD_W-1:0] COMP_MAX =
    PROD_W'((64'sd1 <<< (COMP_W - 1)) - 64'sd1);
  localparam logic signed [PROD_W-1:0] COMP_MIN = -COMP_MAX - PROD_W'(1);

  // Lane 0 carries X with the Y tilt, lane 1 carries Y with the X tilt.
  logic signed [RAW_W-1:0]    raw_s [LANES];
  logic signed [TILT_W-1:0]   tilt_s [LANES];

  logic signed [SUM_W-1:0]    sum_r [LANES];
  logic                       avg_neg_r [LANES];
  logic        [DIV_W-1:0]    mag_r [LANES];
  logic        [TILT_W-2:0]   cos_a_r [LANES];
  logic                       cos_neg_r [LANES];
  logic signed [CORDIC_W-1:0] rx_r [LANES];
  logic signed [CORDIC_W-1:0] ry_r [LANES];
  logic signed [ANG_W-1:0]    rz_r [LANES];
  logic signed [COS_W-1:0]    cos_r [LANES];
  logic signed [COMP_W-1:0]   avg_r [LANES];
  logic signed [PROD_W-1:0]   prod_r [LANES];
  logic signed [COMP_W-1:0]   comp_r [LANES];

  logic signed [CORDIC_W-1:0] vx_r, vy_r;
  logic signed [ANG_W-1:0]    vz_r;
  logic        [HEAD_W-1:0]   heading_r;
  logic signed [COMP_W-1:0]   comp_x_r, comp_y_r;

  // Lane combinational results.
  logic        [SUM_W-1:0]    mag [LANES];
  logic        [TILT_W-2:0]   fold_a [LANES];
  logic                       fold_neg [LANES];
  logic signed [CORDIC_W-1:0] rx_nxt [LANES];
  logic signed [CORDIC_W-1:0] ry_nxt [LANES];
  logic signed [ANG_W-1:0]    rz_nxt [LANES];
  logic signed [COS_W-1:0]    cos_nxt [LANES];
  logic signed [COMP_W-1:0]   avg_nxt [LANES];
  logic signed [COMP_W-1:0]   comp_nxt [LANES];

  // Vectoring combinational results.
  logic signed [CORDIC_W-1:0] vx_init, vy_init, vx_step, vy_step;
  logic signed [ANG_W-1:0]    vz_init, vz_step;
  logic        [HEAD_W-1:0]   heading_nxt;
  logic signed [ANG_W-1:0]    atan_cur;

  assign raw_s[0]  = $signed(compass_x_raw);
  assign raw_s[1]  = $signed(compass_y_raw);
  assign tilt_s[0] = tilt_y_deg;
  assign tilt_s[1] = tilt_x_deg;
  assign atan_cur  = atan_q16(cmd.step);

  // Per-lane load, divide, cosine and saturation logic.
  always_comb begin
    logic signed [TILT_W:0]     t_ext;
    logic        [TILT_W:0]     t_abs;
    logic signed [CORDIC_W-1:0] xs, ys, xc, rnd;
    logic signed [COS_W-1:0]    c_mag;
    logic        [QPROD_W-1:0]  qprod;
    logic        [COMP_W-1:0]   q;
    logic signed [PROD_W-1:0]   trunc;
    for (int l = 0; l < LANES; l++) begin
      // Magnitude of the sum for the divider.
      mag[l] = sum_r[l][SUM_W-1] ? SUM_W'(-sum_r[l]) : SUM_W'(sum_r[l]);

      // Fold the tilt into 0..90 degrees.
      t_ext = {tilt_s[l][TILT_W-1], tilt_s[l]};
      t_abs = t_ext[TILT_W] ? (TILT_W+1)'(-t_ext) : (TILT_W+1)'(t_ext);
      if (t_abs > DEG_QUARTER) begin
        fold_a[l]   = (TILT_W-1)'(DEG_HALF - t_abs);
        fold_neg[l] = 1'b1;
      end else begin
        fold_a[l]   = (TILT_W-1)'(t_abs);
        fold_neg[l] = 1'b0;
      end

      // One rotation CORDIC step toward the residual angle.
      xs = ry_r[l] >>> cmd.step;
      ys = rx_r[l] >>> cmd.step;
      if (!rz_r[l][ANG_W-1]) begin
        rx_nxt[l] = rx_r[l] - xs;
        ry_nxt[l] = ry_r[l] + ys;
        rz_nxt[l] = rz_r[l] - atan_cur;
      end else begin
        rx_nxt[l] = rx_r[l] + xs;
        ry_nxt[l] = ry_r[l] - ys;
        rz_nxt[l] = rz_r[l] + atan_cur;
      end

      // Clamp and round the cosine, with exact values at 0 and 90 degrees.
      if (rx_r[l][CORDIC_W-1]) begin
        xc = '0;
      end else if (rx_r[l] > ONE_Q30) begin
        xc = ONE_Q30;
      end else begin
        xc = rx_r[l];
      end
      rnd = (xc + ROUND_Q30) >>> (Q30_FRAC - COS_FRAC_BITS);
      if (cos_a_r[l] == '0) begin
        c_mag = COS_ONE;
      end else if ({1'b0, cos_a_r[l]} == (TILT_W)'(DEG_QUARTER)) begin
        c_mag = '0;
      end else begin
        c_mag = COS_W'(rnd);
      end
      cos_nxt[l] = cos_neg_r[l] ? -c_mag : c_mag;

      // Divide the magnitude by the period length and apply the sign.
      qprod      = QPROD_W'(mag_r[l]) * QPROD_W'(RECIP);
      q          = COMP_W'(qprod >> RECIP_SH);
      avg_nxt[l] = avg_neg_r[l] ? $signed(-q) : $signed(q);

      // Divide by the cosine scale toward zero and saturate.
      if (prod_r[l][PROD_W-1]) begin
        trunc = (prod_r[l] + TRUNC_BIAS) >>> COS_FRAC_BITS;
      end else begin
        trunc = prod_r[l] >>> COS_FRAC_BITS;
      end
      if (trunc > COMP_MAX) begin
        comp_nxt[l] = COMP_W'(COMP_MAX);
      end else if (trunc < COMP_MIN) begin
        comp_nxt[l] = COMP_W'(COMP_MIN);
      end else begin
        comp_nxt[l] = COMP_W'(trunc);
      end
    end
  end

  // Vectoring setup, one vectoring step and the final angle fold.
  always_comb begin
    logic signed [COMP_W:0]     hx, hy;
    logic signed [CORDIC_W-1:0] xs, ys;
    logic signed [ANG_W-1:0]    z;
    logic        [HEAD_W-1:0]   h;
    hx = {comp_r[0][COMP_W-1], comp_r[0]};
    hy = -{comp_r[1][COMP_W-1], comp_r[1]};
    vx_init = '0;
    vy_init = '0;
    if (hy == '0) begin
      // On the X axis the heading is 0 or 180 degrees.
      vz_init = hx[COMP_W] ? ANG_180 : '0;
    end else if (hx == '0) begin
      // On the Y axis the heading is 90 or 270 degrees.
      vz_init = hy[COMP_W] ? ANG_270 : ANG_90;
    end else if (hx[COMP_W]) begin
      vx_init = CORDIC_W'(-hx) <<< VEC_SHIFT;
      vy_init = CORDIC_W'(-hy) <<< VEC_SHIFT;
      vz_init = ANG_180;
    end else begin
      vx_init = CORDIC_W'(hx) <<< VEC_SHIFT;
      vy_init = CORDIC_W'(hy) <<< VEC_SHIFT;
      vz_init = '0;
    end

    // Rotate the vector toward the X axis.
    xs = vy_r >>> cmd.step;
    ys = vx_r >>> cmd.step;
    if (vy_r > 0) begin
      vx_step = vx_r + xs;
      vy_step = vy_r - ys;
      vz_step = vz_r + atan_cur;
    end else if (vy_r < 0) begin
      vx_step = vx_r - xs;
      vy_step = vy_r + ys;
      vz_step = vz_r - atan_cur;
    end else begin
      vx_step = vx_r;
      vy_step = vy_r;
      vz_step = vz_r;
    end

    // Fold into one turn and keep whole degrees.
    z = vz_r;
    if (z < 0) begin
      z = z + ANG_360;
    end
    if (z >= ANG_360) begin
      z = z - ANG_360;
    end
    if (z < 0) begin
      z = '0;
    end
    h = z[DEG_FRAC+HEAD_W-1:DEG_FRAC];
    heading_nxt = (h > HEAD_MAX) ? HEAD_MAX : h;
  end

  // Running sums: state cleared by reset and at the end of each period.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LANES; l++) begin
        sum_r[l] <= '0;
      end
    end else begin
      for (int l = 0; l < LANES; l++) begin
        if (cmd.load) begin
          sum_r[l] <= '0;
        end else if (cmd.accum) begin
          sum_r[l] <= sum_r[l] + SUM_W'(raw_s[l]);
        end
      end
    end
  end

  // Lane working registers.
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (cmd.load) begin
        avg_neg_r[l] <= sum_r[l][SUM_W-1];
        mag_r[l]     <= DIV_W'(mag[l]);
        cos_a_r[l]   <= fold_a[l];
        cos_neg_r[l] <= fold_neg[l];
        rx_r[l]      <= CORDIC_GAIN_Q30;
        ry_r[l]      <= '0;
        rz_r[l]      <= ANG_W'({fold_a[l], {DEG_FRAC{1'b0}}});
      end else if (cmd.iter) begin
        rx_r[l]  <= rx_nxt[l];
        ry_r[l]  <= ry_nxt[l];
        rz_r[l]  <= rz_nxt[l];
      end
      if (cmd.cosf) begin
        cos_r[l] <= cos_nxt[l];
        avg_r[l] <= avg_nxt[l];
      end
      if (cmd.mul) begin
        prod_r[l] <= PROD_W'(avg_r[l]) * PROD_W'(cos_r[l]);
      end
      if (cmd.sat) begin
        comp_r[l] <= comp_nxt[l];
      end
    end
  end

  // Vectoring registers and the result word.
  always_ff @(posedge clk) begin
    if (cmd.vinit) begin
      vx_r <= vx_init;
      vy_r <= vy_init;
      vz_r <= vz_init;
    end else if (cmd.vstep) begin
      vx_r <= vx_step;
      vy_r <= vy_step;
      vz_r <= vz_step;
    end
    if (cmd.fold) begin
      heading_r <= heading_nxt;
      comp_x_r  <= comp_r[0];
      comp_y_r  <= comp_r[1];
    end
  end

  assign status.vec_zero = (vy_r == '0);
  assign heading_deg     = heading_r;
  assign comp_x_avg      = comp_x_r;
  assign comp_y_avg      = comp_y_r;

endmodule

### rtl/tilt_compensated_compass_heading_unit.sv
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading_unit: averaged, tilt-compensated heading
// Averages compass readings over a period, compensates them with the tilt
// cosines and reports the heading in whole degrees.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one word per compass sample: raw 11-bit X and Y
// readings and two tilt averages in degrees. The first SAMPLES_PER_AVERAGE
// words of a period are summed and produce nothing, and they may arrive back
// to back. The next word closes the period: its compass
// readings are dropped, its tilt fields are used, and it starts the
// computation. The result word on the output channel holds the heading
// (0 to 359) and the two compensated averages.
// After acceptance a closing word runs through the cosine rotation loop,
// then cosine rounding with the averaging division, multiply, saturation
// and vectoring setup, then the vectoring loop (which ends early when the
// residual reaches zero), and last its result is registered. The input is
// not ready during that time.
// The result sits in an output register. A stalled receiver does not hold up
// summing of the next period; only the end of the next computation waits
// for the register to be emptied.
// Reset (rst_n low, synchronous) clears the sums, the sample count, the
// sequencer and the result valid flag.
// ----------------------------------------------------------------------------
module tilt_compensated_compass_heading_unit import tcch_pkg::*; #(
  parameter int SAMPLES_PER_AVERAGE = 8,
  parameter int COS_FRAC_BITS       = 14
) (
  input logic        clk,
  input logic        rst_n,
  tcch_in_if.sink    in_ch,
  tcch_out_if.source out_ch
);

  tcch_cmd_t    cmd;
  tcch_status_t status;

  // Sequencer.
  tcch_ctrl #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic.
  tcch_dpath #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
    .COS_FRAC_BITS       (COS_FRAC_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .compass_x_raw (in_ch.compass_x_raw),
    .compass_y_raw (in_ch.compass_y_raw),
    .tilt_x_deg    (in_ch.tilt_x_deg),
    .tilt_y_deg    (in_ch.tilt_y_deg),
    .status        (status),
    .heading_deg   (out_ch.heading_deg),
    .comp_x_avg    (out_ch.comp_x_avg),
    .comp_y_avg    (out_ch.comp_y_avg)
  );

  // At most one datapath command is active in any cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accum, cmd.load, cmd.iter, cmd.cosf, cmd.mul, cmd.sat,
              cmd.vinit, cmd.vstep, cmd.fold}))
    else $error("more than one datapath command active");

  // A closing word blocks further input while the computation runs.
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_ch.ready)
    else $error("input ready during computation");

  // Registering a result always presents it on the output channel.
  a_fold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fold |=> out_ch.valid)
    else $error("result registered but not presented");

endmodule
